[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions, empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

[design/msort_pkg.sv]
// ----------------------------------------------------------------------------
// Merge sorter package
// Item type carried from the front end to the sort engine, queue constants.
// ----------------------------------------------------------------------------
package msort_pkg;

    localparam int WORD_W = 32;

    // Queue between the front end and the sort engine.
    localparam int QDEPTH = 4;
    localparam int QPW    = 2;

    // One classified item: keep is low for an element dropped at a full store
    // that still has to close the set, ovf tells whether the set overflowed.
    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic                     last;
        logic                     keep;
        logic                     ovf;
    } t_item;

endpackage

[design/msort_front.sv]
// ----------------------------------------------------------------------------
// Merge sorter front end
// Accepts elements, counts them per set, drops those beyond capacity and
// marks the closing item with the set's overflow status.
// ----------------------------------------------------------------------------
module msort_front #(
    parameter int CAPACITY = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [31:0]    i_value,
    input  logic                  i_last_in,
    output logic                  o_item_valid,
    output msort_pkg::t_item      o_item,
    input  logic                  i_full
);
    import msort_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic          r_valid, n_valid;
    t_item         r_item;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovf, n_ovf;
    logic          accept, push, keep;

    assign o_stall      = r_valid && i_full;
    assign accept       = i_valid && !o_stall;
    assign push         = r_valid && !i_full;
    assign keep         = (r_cnt < CW'(CAPACITY));
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_comb begin
        n_valid = r_valid && !push;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        if (accept) begin
            if (keep || i_last_in) begin
                n_valid = 1'b1;
            end
            if (i_last_in) begin
                n_cnt = '0;
                n_ovf = 1'b0;
            end else if (keep) begin
                n_cnt = r_cnt + CW'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (keep || i_last_in)) begin
            r_item.value <= i_value;
            r_item.last  <= i_last_in;
            r_item.keep  <= keep;
            r_item.ovf   <= r_ovf || !keep;
        end
    end

endmodule

[design/msort_fifo.sv]
// ----------------------------------------------------------------------------
// Merge sorter item queue
// Short first-in first-out queue that decouples the front end from the
// sort engine.
// ----------------------------------------------------------------------------
module msort_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  msort_pkg::t_item      i_item,
    output logic                  o_full,
    output logic                  o_valid,
    output msort_pkg::t_item      o_item,
    input  logic                  i_pop
);
    import msort_pkg::*;

    t_item            r_mem [QDEPTH];
    logic [QPW-1:0]   r_wp, r_rp;
    logic [QPW:0]     r_cnt;
    logic             push, pop;

    assign o_full  = (r_cnt == (QPW + 1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign push    = i_valid && !o_full;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + QPW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + QPW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + (QPW + 1)'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - (QPW + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

[design/msort_back.sv]
// ----------------------------------------------------------------------------
// Merge sorter engine
// Stores the elements of a set, sorts them by bottom-up merge passes between
// two memories and streams the result out through an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msort_back #(
    parameter int CAPACITY = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_item_valid,
    input  msort_pkg::t_item      i_item,
    output logic                  o_item_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [31:0]    o_sorted_value,
    output logic                  o_last_out,
    output logic                  o_overflow
);
    import msort_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int SW = CW + 2;

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_START = 4'b0010,
        S_MERGE = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic signed [WORD_W-1:0] r_mem0 [CAPACITY];
    logic signed [WORD_W-1:0] r_mem1 [CAPACITY];
    logic signed [WORD_W-1:0] r_rd_a, r_rd_b;

    logic                     mem_we, mem_wsel, mem_re;
    logic [AW-1:0]            mem_wa, mem_ra, mem_rb;
    logic signed [WORD_W-1:0] mem_wd;

    logic          r_sel, n_sel;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_w, n_w;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_a, n_a, r_b, n_b, r_mid, n_mid, r_hi, n_hi;
    logic          r_rdp, n_rdp;
    logic          r_rdlast, n_rdlast;

    logic                     r_ovalid;
    logic signed [WORD_W-1:0] r_oval;
    logic                     r_olast, r_oovf;

    logic          take_a, out_load, issue;
    logic [CW-1:0] k_inc, load_total;
    logic [SW-1:0] w2, hi_w, hi_2w, seg_mid, seg_hi;

    assign k_inc      = r_k + CW'(1);
    assign load_total = i_item.keep ? (r_cnt + CW'(1)) : r_cnt;
    assign w2         = SW'(r_w) << 1;
    assign hi_w       = SW'(r_hi) + SW'(r_w);
    assign hi_2w      = SW'(r_hi) + w2;
    assign seg_mid    = (hi_w > SW'(r_cnt)) ? SW'(r_cnt) : hi_w;
    assign seg_hi     = (hi_2w > SW'(r_cnt)) ? SW'(r_cnt) : hi_2w;

    // Take the left run when the right run is exhausted or the left value is strictly smaller, so ties go right.
    assign take_a = (r_b >= r_hi) || ((r_a < r_mid) && (r_rd_a < r_rd_b));

    assign out_load = (r_state == S_EMIT) && r_rdp && (!r_ovalid || !i_stall);
    assign issue    = (r_state == S_EMIT) && (r_k != r_cnt) && (!r_rdp || out_load);

    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        n_ovf      = r_ovf;
        n_cnt      = r_cnt;
        n_w        = r_w;
        n_k        = r_k;
        n_a        = r_a;
        n_b        = r_b;
        n_mid      = r_mid;
        n_hi       = r_hi;
        n_rdp      = r_rdp;
        n_rdlast   = r_rdlast;
        o_item_pop = 1'b0;
        mem_we     = 1'b0;
        mem_wsel   = r_sel;
        mem_wa     = r_k[AW-1:0];
        mem_wd     = r_rd_b;
        mem_re     = 1'b0;
        mem_ra     = r_a[AW-1:0];
        mem_rb     = r_b[AW-1:0];

        unique case (r_state)
            S_LOAD: begin
                o_item_pop = i_item_valid;
                if (i_item_valid) begin
                    if (i_item.keep) begin
                        mem_we = 1'b1;
                        mem_wa = r_cnt[AW-1:0];
                        mem_wd = i_item.value;
                    end
                    n_cnt = load_total;
                    if (i_item.last) begin
                        n_ovf = i_item.ovf;
                        n_w   = CW'(1);
                        n_k   = '0;
                        n_rdp = 1'b0;
                        if (load_total == CW'(1)) begin
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_START;
                        end
                    end
                end
            end
            S_START: begin
                mem_re  = 1'b1;
                mem_ra  = '0;
                mem_rb  = r_w[AW-1:0];
                n_a     = '0;
                n_b     = r_w;
                n_mid   = r_w;
                n_hi    = (w2 > SW'(r_cnt)) ? r_cnt : w2[CW-1:0];
                n_k     = '0;
                n_state = S_MERGE;
            end
            S_MERGE: begin
                mem_we   = 1'b1;
                mem_wsel = !r_sel;
                mem_wd   = take_a ? r_rd_a : r_rd_b;
                n_k      = k_inc;
                if (k_inc == r_cnt) begin
                    // Pass complete: the scratch side becomes the source.
                    n_sel = !r_sel;
                    n_w   = w2[CW-1:0];
                    n_k   = '0;
                    if (w2 >= SW'(r_cnt)) begin
                        n_rdp   = 1'b0;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_START;
                    end
                end else if (k_inc == r_hi) begin
                    // Next pair of runs starts where this one ended.
                    mem_re = 1'b1;
                    mem_ra = r_hi[AW-1:0];
                    mem_rb = seg_mid[AW-1:0];
                    n_a    = r_hi;
                    n_b    = seg_mid[CW-1:0];
                    n_mid  = seg_mid[CW-1:0];
                    n_hi   = seg_hi[CW-1:0];
                end else begin
                    n_a    = take_a ? (r_a + CW'(1)) : r_a;
                    n_b    = take_a ? r_b : (r_b + CW'(1));
                    mem_re = 1'b1;
                    mem_ra = n_a[AW-1:0];
                    mem_rb = n_b[AW-1:0];
                end
            end
            S_EMIT: begin
                mem_ra = r_k[AW-1:0];
                mem_rb = r_k[AW-1:0];
                if (issue) begin
                    mem_re   = 1'b1;
                    n_k      = k_inc;
                    n_rdp    = 1'b1;
                    n_rdlast = (k_inc == r_cnt);
                end else if (out_load) begin
                    n_rdp = 1'b0;
                end
                if ((r_k == r_cnt) && !r_rdp) begin
                    n_cnt   = '0;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            if (mem_wsel) begin
                r_mem1[mem_wa] <= mem_wd;
            end else begin
                r_mem0[mem_wa] <= mem_wd;
            end
        end
        if (mem_re) begin
            r_rd_a <= r_sel ? r_mem1[mem_ra] : r_mem0[mem_ra];
            r_rd_b <= r_sel ? r_mem1[mem_rb] : r_mem0[mem_rb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_sel    <= 1'b0;
            r_ovf    <= 1'b0;
            r_cnt    <= '0;
            r_rdp    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_ovf   <= n_ovf;
            r_cnt   <= n_cnt;
            r_rdp   <= n_rdp;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_w      <= n_w;
        r_k      <= n_k;
        r_a      <= n_a;
        r_b      <= n_b;
        r_mid    <= n_mid;
        r_hi     <= n_hi;
        r_rdlast <= n_rdlast;
        if (out_load) begin
            r_oval  <= r_rd_a;
            r_olast <= r_rdlast;
            r_oovf  <= r_ovf;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_sorted_value = r_oval;
    assign o_last_out     = r_olast;
    assign o_overflow     = r_oovf;

    `ASSERT_ALWAYS(a_merge_in_range, i_clk, i_rst_n,
        (r_state == S_MERGE) |-> (r_k < r_cnt))
    `ASSERT_ALWAYS(a_run_ptrs, i_clk, i_rst_n,
        (r_state == S_MERGE) |-> ((r_a <= r_mid) && (r_b <= r_hi) && (r_hi <= r_cnt)))
    `ASSERT_ALWAYS(a_start_width, i_clk, i_rst_n,
        (r_state == S_START) |-> ((r_w < r_cnt) && (r_cnt > CW'(1))))
    `ASSERT_NEVER(a_pop_outside_load, i_clk, i_rst_n,
        o_item_pop && (r_state != S_LOAD))

endmodule

[design/merge_sorter.sv]
// ----------------------------------------------------------------------------
// Merge sorter
// Collects a set of signed 32-bit elements, sorts it ascending, streams it out.
// ----------------------------------------------------------------------------
// Usage: elements enter on the input channel (i_valid, o_stall, i_value,
// i_last_in); the element with i_last_in high closes the set. At most
// CAPACITY elements of a set are kept; later ones are dropped, but a dropped
// closing element still closes the set, and every output of that set then
// carries o_overflow. The sorted set leaves on the output channel (o_valid,
// i_stall, o_sorted_value, o_last_out, o_overflow), one item per cycle while
// the receiver does not stall, with o_last_out on the largest element.
// For a set of n kept elements: the sort engine stores one element a cycle
// while the queue holds items, then runs ceil(log2 n) merge passes (one
// compare and one memory write per cycle), then streams n results; the merge
// passes over the two element memories take most of that time.
// A four-entry queue lets the front end take elements of the next set while
// the engine sorts. A stalled receiver holds the output register; the engine
// then waits and the input side stalls once the queue fills. Reset is
// synchronous and empties the queue, the counters and the output register.
// ----------------------------------------------------------------------------
module merge_sorter #(
    parameter int CAPACITY = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [31:0]    i_value,
    input  logic                  i_last_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [31:0]    o_sorted_value,
    output logic                  o_last_out,
    output logic                  o_overflow
);
    import msort_pkg::*;

    // Front end to queue.
    logic  front_valid;
    t_item front_item;
    logic  q_full;

    // Queue to sort engine.
    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    // The front end counts elements per set and tags each item with whether
    // it is stored and whether the set has overflowed so far.
    msort_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .i_last_in    (i_last_in),
        .o_item_valid (front_valid),
        .o_item       (front_item),
        .i_full       (q_full)
    );

    // The queue absorbs items while the engine is busy sorting or emitting.
    msort_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    // The engine only drains the queue while it is collecting a set.
    msort_back #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (q_valid),
        .i_item         (q_item),
        .o_item_pop     (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out),
        .o_overflow     (o_overflow)
    );

endmodule

[test/tb_merge_sorter.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Merge sorter testbench
// Sends sets of signed 32-bit elements into the sorter and checks every
// sorted item against an in-bench prediction of the sorted set.
// ----------------------------------------------------------------------------
// The input side sends sets of elements and closes each set with i_last_in.
// Each kept element also goes into a software copy of the open set.
// When a set closes, that copy is sorted ascending and one expected item per
// kept element is queued, with the last flag on the largest and the overflow
// flag on all of them if elements were dropped. The output side compares each
// accepted item with the oldest expected one. Both sides insert random idle
// cycles, except in stretches where idling is switched off. A watchdog ends
// the run when nothing moves on either channel for too long.
// ----------------------------------------------------------------------------
module tb_merge_sorter;

    import msort_pkg::*;

    // The block is built with its full capacity of 64 elements per set.
    localparam int SET_CAP        = 64;
    // The limit leaves a wide margin above the time a full set takes from its
    // closing element to its first result.
    localparam int WATCHDOG_LIMIT = 5000;
    // Cycles to wait after the last expected item for any stray output.
    localparam int TAIL_CYCLES    = 400;
    localparam int RANDOM_ITEMS   = 250;

    localparam logic signed [WORD_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] MOST_POS = 32'sh7fff_ffff;

    // One expected item of the sorted output stream.
    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic                     last;
        logic                     ovf;
    } t_sorted_item;

    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_valid        = 1'b0;
    logic signed [WORD_W-1:0] i_value        = '0;
    logic                     i_last_in      = 1'b0;
    logic                     i_stall        = 1'b0;
    logic                     o_stall;
    logic                     o_valid;
    logic signed [WORD_W-1:0] o_sorted_value;
    logic                     o_last_out;
    logic                     o_overflow;

    // Prediction state: the open set as the block should hold it, and the
    // sorted items that are still owed by the block.
    logic signed [WORD_W-1:0] open_set_q[$];
    bit                       open_set_dropped;
    t_sorted_item             sorted_expect_q[$];

    // Idle switches for the two sides and the run statistics.
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int stall_left = 0;
    int quiet_cycles = 0;
    int fail_count = 0;
    int elements_sent = 0;
    int sets_closed = 0;
    int overflow_sets = 0;
    int items_checked = 0;

    merge_sorter #(
        .CAPACITY(SET_CAP)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_value        (i_value),
        .i_last_in      (i_last_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out),
        .o_overflow     (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    // Adds one accepted element to the open set. A closing element sorts the
    // kept elements and queues one expected item per kept element. An element
    // that finds the set full is dropped, even when it closes the set.
    task automatic predict_element(input logic signed [WORD_W-1:0] value,
                                   input logic last);
        logic signed [WORD_W-1:0] held;
        t_sorted_item             item;
        int                       j;
        if (open_set_q.size() < SET_CAP) begin
            open_set_q.push_back(value);
        end else begin
            open_set_dropped = 1'b1;
        end
        if (last) begin
            // Insertion sort; equal values are indistinguishable in the
            // output, so the tie order of the merge does not matter here.
            for (int i = 1; i < open_set_q.size(); i++) begin
                held = open_set_q[i];
                j = i - 1;
                while (j >= 0 && open_set_q[j] > held) begin
                    open_set_q[j + 1] = open_set_q[j];
                    j--;
                end
                open_set_q[j + 1] = held;
            end
            foreach (open_set_q[i]) begin
                item.value = open_set_q[i];
                item.last  = (i == open_set_q.size() - 1);
                item.ovf   = open_set_dropped;
                sorted_expect_q.push_back(item);
            end
            sets_closed++;
            if (open_set_dropped) begin
                overflow_sets++;
            end
            open_set_q.delete();
            open_set_dropped = 1'b0;
        end
    endtask

    // Sends one element after a random gap and returns at the edge where it
    // is accepted. With no gap, valid simply stays high from the last item.
    task automatic send_element(input logic signed [WORD_W-1:0] value,
                                input logic last);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_value   <= value;
        i_last_in <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        elements_sent++;
        predict_element(value, last);
    endtask

    // Lowers valid after the final element of a test and holds off until
    // every sorted item owed so far has come out.
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        while (sorted_expect_q.size() != 0) @(posedge i_clk);
    endtask

    // Element values: mostly fully random, some from a narrow range so that
    // ties are common, some at the two ends of the signed range.
    function automatic logic signed [WORD_W-1:0] random_element();
        case ($urandom_range(0, 5))
            0:       return $signed($urandom_range(0, 6)) - 3;
            1:       return ($urandom_range(0, 1) != 0) ? MOST_POS : MOST_NEG;
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic send_random_set(input int size);
        for (int i = 0; i < size; i++) begin
            send_element(random_element(), i == size - 1);
        end
    endtask

    // Sets of one element, with the two signed extremes and zero.
    task automatic test_single_element_sets();
        send_element(MOST_NEG, 1'b1);
        send_element(MOST_POS, 1'b1);
        send_element('0, 1'b1);
        wait_results_drained();
    endtask

    // One set holding the extremes, the values around zero and alternating
    // bit patterns, so that every bit of the value is both 0 and 1.
    task automatic test_extreme_values();
        send_element(MOST_POS, 1'b0);
        send_element(MOST_NEG, 1'b0);
        send_element('0, 1'b0);
        send_element(-1, 1'b0);
        send_element(1, 1'b0);
        send_element(MOST_NEG + 1, 1'b0);
        send_element(MOST_POS - 1, 1'b0);
        send_element(32'sh5555_5555, 1'b0);
        send_element(32'shAAAA_AAAA, 1'b1);
        wait_results_drained();
    endtask

    // Equal values within a set, a reversed set and a two-element set.
    task automatic test_ties_and_order();
        send_element(5, 1'b0);
        send_element(5, 1'b0);
        send_element(-3, 1'b0);
        send_element(5, 1'b0);
        send_element(-3, 1'b0);
        send_element(0, 1'b0);
        send_element(0, 1'b1);
        for (int v = 4; v >= 1; v--) begin
            send_element(v, v == 1);
        end
        send_element(2, 1'b0);
        send_element(-2, 1'b1);
        wait_results_drained();
    endtask

    // A set of exactly the capacity, sent and read without idle cycles, then
    // a set one element too long, whose closing element finds the store full.
    task automatic test_capacity_edges();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_random_set(SET_CAP);
        wait_results_drained();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_random_set(SET_CAP + 1);
        wait_results_drained();
    endtask

    // Back-to-back sets of random sizes, mostly small, with the idle switches
    // drawn anew per set. Halfway through, the sender holds off once until
    // the block has caught up.
    task automatic test_random_sets();
        int start_count;
        bit paused;
        start_count = elements_sent;
        paused = 1'b0;
        while (elements_sent - start_count < RANDOM_ITEMS) begin
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) begin
                send_random_set($urandom_range(13, 40));
            end else begin
                send_random_set($urandom_range(1, 12));
            end
            if (!paused && elements_sent - start_count >= RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                wait_results_drained();
            end
        end
        wait_results_drained();
    endtask

    // Output side: checks each accepted item against the oldest expected one
    // and then draws how many cycles to stall before taking the next.
    always @(posedge i_clk) begin
        t_sorted_item want;
        if (!i_rst_n) begin
            stall_left = 0;
        end else if (o_valid && !i_stall) begin
            if (sorted_expect_q.size() == 0) begin
                $display("%0t: unexpected item: value %0d last %0b overflow %0b",
                         $time, o_sorted_value, o_last_out, o_overflow);
                fail_count++;
            end else begin
                want = sorted_expect_q.pop_front();
                items_checked++;
                if (o_sorted_value !== want.value) begin
                    $display("%0t: sorted_value mismatch: expected %0d, got %0d",
                             $time, want.value, o_sorted_value);
                    fail_count++;
                end
                if (o_last_out !== want.last) begin
                    $display("%0t: last_out mismatch: expected %0b, got %0b",
                             $time, want.last, o_last_out);
                    fail_count++;
                end
                if (o_overflow !== want.ovf) begin
                    $display("%0t: overflow mismatch: expected %0b, got %0b",
                             $time, want.ovf, o_overflow);
                    fail_count++;
                end
            end
            stall_left = rx_idle_en ? $urandom_range(0, 3) : 0;
        end else if (stall_left > 0) begin
            stall_left--;
        end
        i_stall <= (stall_left > 0);
    end

    // Watchdog: counts cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d sorted items still owed",
                     $time, WATCHDOG_LIMIT, sorted_expect_q.size());
            $display("tb_merge_sorter NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        open_set_dropped = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_element_sets();
        test_extreme_values();
        test_ties_and_order();
        test_capacity_edges();
        test_random_sets();

        // Any item that shows up now has no expectation and is flagged.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        fail_count += sorted_expect_q.size();

        $display("Sent %0d elements in %0d sets, %0d of them overflowing;",
                 elements_sent, sets_closed, overflow_sets);
        $display("checked %0d sorted items, %0d failures.", items_checked, fail_count);
        if (fail_count == 0) begin
            $display("tb_merge_sorter OK");
        end else begin
            $display("tb_merge_sorter NOT OK");
        end
        $finish;
    end

endmodule
